// ===== rtl/descending_list_sorter_macros.svh =====
// Assertion macros shared by the descending list sorter RTL.
`ifndef DESCENDING_LIST_SORTER_MACROS_SVH
`define DESCENDING_LIST_SORTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("descending_list_sorter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("descending_list_sorter: next-cycle check failed");

`endif

// ===== rtl/dls_pkg.sv =====
// Types and constants shared by the descending list sorter modules.
package dls_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [RANK_W-1:0]         rank_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the broadcast value
        logic drain;  // shift the chain one cell toward the head
    } dls_ctrl_t;

endpackage

// ===== rtl/descending_list_sorter.sv =====
// Top level of the descending list sorter: chain of insertion cells plus control.
// A list of signed 32-bit values streams in one beat per cycle; each beat is
// inserted into a chain of DEPTH comparing cells, which keep the list in
// descending order (equal values keep arrival order). The beat flagged with
// s_last_item is inserted like the others and then the whole list is emitted,
// greatest first: one result beat per stored value, with its rank (0 is the
// maximum), last_of_run on the smallest, and overflow set on every beat of a
// list that brought more than DEPTH values (the surplus is dropped). Each beat
// is placed by the single broadcast compare in each cell. Emission shifts the
// chain toward its head, one result beat per stored value, holding while
// m_ready is low; s_ready is low from the accepted last beat until the final
// result beat is accepted, then the block is empty again.
module descending_list_sorter #(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dls_pkg::value_t       s_value,
    input  logic                  s_last_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dls_pkg::value_t       m_sorted_value,
    output dls_pkg::rank_t        m_rank,
    output logic                  m_last_of_run,
    output logic                  m_overflow
);
    import dls_pkg::*;

`include "descending_list_sorter_macros.svh"

    localparam int COUNT_W = $clog2(DEPTH + 1);

    // Control state: fill count, drain flag, output rank, drop flag.
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               drain_reg;
    logic               drain_next;
    rank_t              rank_reg;
    rank_t              rank_next;
    logic               dropped_reg;
    logic               dropped_next;

    logic      s_fire;
    logic      m_fire;
    logic      full;
    dls_ctrl_t ctrl;

    // Chain wiring between neighboring cells.
    logic   ge_w    [DEPTH];
    value_t value_w [DEPTH];

    assign full    = (count_reg == COUNT_W'(DEPTH));
    assign s_ready = !drain_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = drain_reg;
    assign m_fire  = m_valid && m_ready;

    // Insert only when a cell is free; a beat on a full chain is dropped.
    assign ctrl.load  = s_fire && !full;
    assign ctrl.drain = m_fire;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic   prev_ge_c;
            value_t prev_value_c;
            value_t next_value_c;

            if (gi == 0) begin : g_head
                // The head has no predecessor: the new value lands here if it wins.
                assign prev_ge_c    = 1'b1;
                assign prev_value_c = s_value;
            end else begin : g_body
                assign prev_ge_c    = ge_w[gi-1];
                assign prev_value_c = value_w[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign next_value_c = value_w[gi];
            end else begin : g_mid
                assign next_value_c = value_w[gi+1];
            end

            dls_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .in_value   (s_value),
                .live       (COUNT_W'(gi) < count_reg),
                .prev_ge    (prev_ge_c),
                .prev_value (prev_value_c),
                .next_value (next_value_c),
                .ge         (ge_w[gi]),
                .value      (value_w[gi])
            );
        end
    endgenerate

    // Result beat comes straight off the head cell.
    assign m_sorted_value = value_w[0];
    assign m_rank         = rank_reg;
    assign m_last_of_run  = (count_reg == COUNT_W'(1));
    assign m_overflow     = dropped_reg;

    always_comb begin
        count_next   = count_reg;
        drain_next   = drain_reg;
        rank_next    = rank_reg;
        dropped_next = dropped_reg;
        if (s_fire) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + COUNT_W'(1);
            end
            if (s_last_item) begin
                drain_next = 1'b1;
            end
        end
        if (m_fire) begin
            count_next = count_reg - COUNT_W'(1);
            rank_next  = rank_reg + RANK_W'(1);
            if (m_last_of_run) begin
                // Final beat of the run: return to an empty chain.
                drain_next   = 1'b0;
                rank_next    = '0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            drain_reg   <= 1'b0;
            rank_reg    <= '0;
            dropped_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            drain_reg   <= drain_next;
            rank_reg    <= rank_next;
            dropped_reg <= dropped_next;
        end
    end

    // Fill never exceeds the chain length.
    `DLS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= COUNT_W'(DEPTH))
    // Head of the chain is never smaller than its neighbor while draining.
    `DLS_ASSERT_NOW(a_head_order, aclk, aresetn, m_valid && (count_reg > COUNT_W'(1)),
                    value_w[0] >= value_w[1])
    // A drain always has at least one value to emit.
    `DLS_ASSERT_NOW(a_drain_nonempty, aclk, aresetn, m_valid, count_reg != '0)
    // The last input beat starts emission on the next cycle.
    `DLS_ASSERT_NEXT(a_last_starts, aclk, aresetn, s_fire && s_last_item, m_valid)
    // Taking the final result leaves an empty, clean chain.
    `DLS_ASSERT_NEXT(a_run_ends, aclk, aresetn, m_fire && m_last_of_run,
                     !m_valid && (count_reg == '0) && !m_overflow)

endmodule

// ===== rtl/dls_cell.sv =====
// One cell of the sorting chain: holds one value in descending order.
module dls_cell (
    input  logic              aclk,
    input  dls_pkg::dls_ctrl_t ctrl,
    input  dls_pkg::value_t   in_value,
    input  logic              live,
    input  logic              prev_ge,
    input  dls_pkg::value_t   prev_value,
    input  dls_pkg::value_t   next_value,
    output logic              ge,
    output dls_pkg::value_t   value
);
    import dls_pkg::*;

    value_t value_reg;
    value_t value_next;

    // Keep own value when it is live and not smaller than the new one.
    assign ge    = live && (value_reg >= in_value);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.load) begin
            if (ge) begin
                value_next = value_reg;
            end else if (prev_ge) begin
                value_next = in_value;
            end else begin
                value_next = prev_value;
            end
        end else if (ctrl.drain) begin
            value_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule
